### rtl/smpq_pkg.sv
// Shared constants, types and codes for the stable minimum priority queue.
`timescale 1ns / 1ps

package smpq_pkg;

   localparam int CAPACITY        = 16;
   localparam int ELEM_WIDTH      = 32;
   localparam int PRIO_WIDTH      = 16;
   localparam int CNT_WIDTH       = $clog2(CAPACITY + 1);
   localparam int COUNT_OUT_WIDTH = 5;
   localparam int ERR_WIDTH       = 2;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [ERR_WIDTH-1:0] {
      ERR_OK    = 2'd0,
      ERR_FULL  = 2'd1,
      ERR_EMPTY = 2'd2
   } err_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
   } cmd_type;

endpackage

### rtl/smpq_ctrl.sv
// Controller state machine that sequences request capture, queue update and response.
`timescale 1ns / 1ps

module smpq_ctrl
   import smpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         ST_EXEC: begin
            cmd.exec = out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

   assign rsp_valid_in = cmd.exec || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/smpq_datapath.sv
// Datapath with the sorted slot array, request register and response register.
`timescale 1ns / 1ps

module smpq_datapath
   import smpq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   input  logic                       req_operation,
   input  logic [ELEM_WIDTH-1:0]      req_elem,
   input  logic [PRIO_WIDTH-1:0]      req_priority_req,
   output logic [ELEM_WIDTH-1:0]      rsp_front_elem,
   output logic [PRIO_WIDTH-1:0]      rsp_front_priority,
   output logic [COUNT_OUT_WIDTH-1:0] rsp_entry_count,
   output logic                       rsp_is_empty,
   output logic [ERR_WIDTH-1:0]       rsp_error
);

   logic [ELEM_WIDTH-1:0]      slot_elem_ff [CAPACITY];
   logic [PRIO_WIDTH-1:0]      slot_prio_ff [CAPACITY];
   logic [ELEM_WIDTH-1:0]      slot_elem_in [CAPACITY];
   logic [PRIO_WIDTH-1:0]      slot_prio_in [CAPACITY];
   logic [CNT_WIDTH-1:0]       count_ff;
   logic [CNT_WIDTH-1:0]       count_in;
   logic                       op_ff;
   logic [ELEM_WIDTH-1:0]      elem_ff;
   logic [PRIO_WIDTH-1:0]      prio_ff;
   logic [CAPACITY-1:0]        le;
   logic                       full;
   logic                       empty;
   err_type                    err_in;
   logic [ELEM_WIDTH-1:0]      front_elem_ff;
   logic [PRIO_WIDTH-1:0]      front_prio_ff;
   logic [COUNT_OUT_WIDTH-1:0] entry_count_ff;
   logic                       is_empty_ff;
   err_type                    error_ff;

   assign full  = (count_ff == CNT_WIDTH'(CAPACITY));
   assign empty = (count_ff == '0);

   // A slot keeps its entry when it is occupied and ranks at or ahead of the new one.
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         le[i] = (CNT_WIDTH'(i) < count_ff) && (slot_prio_ff[i] <= prio_ff);
      end
   end

   always_comb begin
      slot_elem_in = slot_elem_ff;
      slot_prio_in = slot_prio_ff;
      count_in     = count_ff;
      err_in       = ERR_OK;
      if (op_ff == OP_ENQUEUE) begin
         if (full) begin
            err_in = ERR_FULL;
         end else begin
            if (!le[0]) begin
               slot_elem_in[0] = elem_ff;
               slot_prio_in[0] = prio_ff;
            end
            for (int i = 1; i < CAPACITY; i++) begin
               if (!le[i]) begin
                  if (le[i-1]) begin
                     slot_elem_in[i] = elem_ff;
                     slot_prio_in[i] = prio_ff;
                  end else begin
                     slot_elem_in[i] = slot_elem_ff[i-1];
                     slot_prio_in[i] = slot_prio_ff[i-1];
                  end
               end
            end
            count_in = count_ff + 1'b1;
         end
      end else begin
         if (empty) begin
            err_in = ERR_EMPTY;
         end else begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
               slot_elem_in[i] = slot_elem_ff[i+1];
               slot_prio_in[i] = slot_prio_ff[i+1];
            end
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= req_operation;
         elem_ff <= req_elem;
         prio_ff <= req_priority_req;
      end
      if (cmd.exec) begin
         slot_elem_ff   <= slot_elem_in;
         slot_prio_ff   <= slot_prio_in;
         front_elem_ff  <= (count_in == '0) ? '0 : slot_elem_in[0];
         front_prio_ff  <= (count_in == '0) ? '0 : slot_prio_in[0];
         entry_count_ff <= COUNT_OUT_WIDTH'(count_in);
         is_empty_ff    <= (count_in == '0);
         error_ff       <= err_in;
      end
   end

   assign rsp_front_elem     = front_elem_ff;
   assign rsp_front_priority = front_prio_ff;
   assign rsp_entry_count    = entry_count_ff;
   assign rsp_is_empty       = is_empty_ff;
   assign rsp_error          = error_ff;

endmodule

### rtl/stable_min_priority_queue.sv
// Top level of the stable minimum priority queue.
//
//   Channel   Direction   Handshake            Payload
//   req_      in          req_valid/req_stall  operation, elem, priority_req
//   rsp_      out         rsp_valid/rsp_stall  front_elem, front_priority, entry_count,
//                                              is_empty, error
//
// Each transaction first captures the request and then updates the sorted slot array,
// where all slots compare against the new priority in parallel.
// A response still held by rsp_stall delays the update cycle until the register frees.
// Reset clears the controller, the response valid flag and the entry count; slot
// contents are not cleared, since only occupied slots are ever read.
`timescale 1ns / 1ps

module stable_min_priority_queue
   import smpq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic [ELEM_WIDTH-1:0]      req_elem,
   input  logic [PRIO_WIDTH-1:0]      req_priority_req,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ELEM_WIDTH-1:0]      rsp_front_elem,
   output logic [PRIO_WIDTH-1:0]      rsp_front_priority,
   output logic [COUNT_OUT_WIDTH-1:0] rsp_entry_count,
   output logic                       rsp_is_empty,
   output logic [ERR_WIDTH-1:0]       rsp_error
);

   cmd_type cmd;

   smpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   smpq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_operation      (req_operation),
      .req_elem           (req_elem),
      .req_priority_req   (req_priority_req),
      .rsp_front_elem     (rsp_front_elem),
      .rsp_front_priority (rsp_front_priority),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_error          (rsp_error)
   );

endmodule

### verif/testbench.sv
// Self-checking testbench for the stable minimum priority queue.
`timescale 1ns / 1ps

module testbench;
   import smpq_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 80;
   localparam int RANDOM_ITEMS = 1000;
   localparam int PRINT_LIMIT  = 100;

   typedef struct {
      logic [ELEM_WIDTH-1:0]      front_elem;
      logic [PRIO_WIDTH-1:0]      front_priority;
      logic [COUNT_OUT_WIDTH-1:0] entry_count;
      logic                       is_empty;
      err_type                    error;
   } queue_status_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_operation = OP_ENQUEUE;
   logic [ELEM_WIDTH-1:0]      req_elem = '0;
   logic [PRIO_WIDTH-1:0]      req_priority_req = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [ELEM_WIDTH-1:0]      rsp_front_elem;
   logic [PRIO_WIDTH-1:0]      rsp_front_priority;
   logic [COUNT_OUT_WIDTH-1:0] rsp_entry_count;
   logic                       rsp_is_empty;
   logic [ERR_WIDTH-1:0]       rsp_error;

   logic [ELEM_WIDTH-1:0] model_elem [CAPACITY];
   logic [PRIO_WIDTH-1:0] model_prio [CAPACITY];
   int                    model_count = 0;
   queue_status_type      expected_status [$];

   int error_count = 0;
   int idle_cycles = 0;
   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   bit hold_request = 1'b0;

   stable_min_priority_queue uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_elem           (req_elem),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_front_elem     (rsp_front_elem),
      .rsp_front_priority (rsp_front_priority),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_is_empty       (rsp_is_empty),
      .rsp_error          (rsp_error)
   );

   always #1 clock = ~clock;

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
      error_count++;
   endtask

   function automatic void predict_status(input op_type op, input logic [ELEM_WIDTH-1:0] e,
                                          input logic [PRIO_WIDTH-1:0] p);
      queue_status_type s;
      int pos;
      s.error = ERR_OK;
      if (op == OP_ENQUEUE) begin
         if (model_count >= CAPACITY) begin
            s.error = ERR_FULL;
         end else begin
            pos = 0;
            while (pos < model_count && p >= model_prio[pos]) pos++;
            for (int i = model_count; i > pos; i--) begin
               model_elem[i] = model_elem[i-1];
               model_prio[i] = model_prio[i-1];
            end
            model_elem[pos] = e;
            model_prio[pos] = p;
            model_count++;
         end
      end else if (model_count == 0) begin
         s.error = ERR_EMPTY;
      end else begin
         for (int i = 0; i + 1 < model_count; i++) begin
            model_elem[i] = model_elem[i+1];
            model_prio[i] = model_prio[i+1];
         end
         model_count--;
      end
      if (model_count == 0) begin
         s.front_elem     = '0;
         s.front_priority = '0;
         s.is_empty       = 1'b1;
      end else begin
         s.front_elem     = model_elem[0];
         s.front_priority = model_prio[0];
         s.is_empty       = 1'b0;
      end
      s.entry_count = COUNT_OUT_WIDTH'(model_count);
      expected_status.push_back(s);
   endfunction

   task automatic send_request(input op_type op, input logic [ELEM_WIDTH-1:0] e,
                               input logic [PRIO_WIDTH-1:0] p);
      int gap;
      gap = req_idle ? $urandom_range(7, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_elem         <= e;
      req_priority_req <= p;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      predict_status(op, e, p);
   endtask

   function automatic logic [PRIO_WIDTH-1:0] pick_priority(input int mode);
      case (mode)
         0: return PRIO_WIDTH'($urandom_range(3, 0));
         1: return $urandom_range(1, 0) ? '1 : '0;
         default: return PRIO_WIDTH'($urandom());
      endcase
   endfunction

   task automatic check_status;
      queue_status_type s;
      if (expected_status.size() == 0) begin
         report_mismatch("transaction received with nothing expected");
      end else begin
         s = expected_status.pop_front();
         if (rsp_front_elem !== s.front_elem)
            report_mismatch($sformatf("front_elem got %h expected %h",
                                      rsp_front_elem, s.front_elem));
         if (rsp_front_priority !== s.front_priority)
            report_mismatch($sformatf("front_priority got %h expected %h",
                                      rsp_front_priority, s.front_priority));
         if (rsp_entry_count !== s.entry_count)
            report_mismatch($sformatf("entry_count got %0d expected %0d",
                                      rsp_entry_count, s.entry_count));
         if (rsp_is_empty !== s.is_empty)
            report_mismatch($sformatf("is_empty got %b expected %b",
                                      rsp_is_empty, s.is_empty));
         if (rsp_error !== s.error)
            report_mismatch($sformatf("error got %0d expected %0d",
                                      rsp_error, s.error));
      end
   endtask

   initial begin
      int n;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         n = rsp_idle ? $urandom_range(7, 0) : 0;
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         check_status();
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic test_empty_dequeue;
      send_request(OP_DEQUEUE, $urandom(), PRIO_WIDTH'($urandom()));
      send_request(OP_DEQUEUE, '1, '1);
   endtask

   task automatic test_field_extremes;
      send_request(OP_ENQUEUE, '0, '1);
      send_request(OP_ENQUEUE, '1, '0);
      send_request(OP_ENQUEUE, 32'h5555_5555, 16'h8000);
      send_request(OP_ENQUEUE, 32'hAAAA_AAAA, 16'h0001);
      repeat (4) send_request(OP_DEQUEUE, '0, '0);
      send_request(OP_DEQUEUE, '0, '0);
   endtask

   task automatic test_stable_order;
      send_request(OP_ENQUEUE, 32'h0000_0001, 16'd7);
      send_request(OP_ENQUEUE, 32'h0000_0002, 16'd7);
      send_request(OP_ENQUEUE, 32'h0000_0003, 16'd3);
      send_request(OP_ENQUEUE, 32'h0000_0004, 16'd7);
      send_request(OP_ENQUEUE, 32'h0000_0005, 16'd3);
      repeat (5) send_request(OP_DEQUEUE, '0, '0);
   endtask

   task automatic test_full_queue;
      repeat (CAPACITY + 3) send_request(OP_ENQUEUE, $urandom(), pick_priority(0));
      repeat (CAPACITY + 2) send_request(OP_DEQUEUE, $urandom(), PRIO_WIDTH'($urandom()));
   endtask

   task automatic test_backpressure;
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      hold_request = 1'b1;
      repeat (30) begin
         send_request($urandom_range(3, 0) == 0 ? OP_DEQUEUE : OP_ENQUEUE,
                      $urandom(), pick_priority(2));
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   task automatic test_random_traffic;
      int sent;
      int enq_pct;
      int prio_mode;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(2, 0))
            0: enq_pct = 25;
            1: enq_pct = 50;
            default: enq_pct = 80;
         endcase
         prio_mode = $urandom_range(2, 0);
         req_idle  = 1'($urandom_range(1, 0));
         rsp_idle  = 1'($urandom_range(1, 0));
         repeat (40) begin
            send_request($urandom_range(99, 0) < enq_pct ? OP_ENQUEUE : OP_DEQUEUE,
                         $urandom(), pick_priority(prio_mode));
            sent++;
         end
      end
      req_idle = 1'b1;
      rsp_idle = 1'b1;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_dequeue();
      test_field_extremes();
      test_stable_order();
      test_full_queue();
      test_backpressure();
      test_random_traffic();
      test_full_queue();
      req_valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
